@@ rtl/tcw_pkg.sv @@
package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam int KIND_W = 2;
  localparam int CHAR_W = 8;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int POS_W  = 11;
  localparam int DATA_W = 16;

  localparam logic [CHAR_W-1:0] ATTR_WHITE = 8'h0F;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'd10;
  localparam logic [DATA_W-1:0] BLANK_CELL = {ATTR_WHITE, CHAR_SPACE};

  typedef enum logic [KIND_W-1:0] {
    KIND_CHAR  = 2'd0,
    KIND_SET   = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_READ  = 2'd3
  } kind_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic set_cursor;
    logic col_zero;
    logic col_inc;
    logic row_inc;
    logic wr_char;
    logic wr_blank;
    logic wr_copy;
    logic rd_item;
    logic rd_copy;
    logic sweep_clr;
    logic sweep_inc;
    logic load_out;
  } tcw_cmd_t;

  // datapath to controller
  typedef struct packed {
    kind_t kind;
    logic  is_cr;
    logic  is_lf;
    logic  is_print;
    logic  col_last;
    logic  row_last;
    logic  sweep_zero;
    logic  copy_end;
    logic  fill_end;
    logic  out_free;
  } tcw_stat_t;

endpackage

@@ rtl/tcw_if.sv @@
interface tcw_in_if import tcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [CHAR_W-1:0] char_code;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;

  modport source (output valid, kind, char_code, col, row, input ready);
  modport sink   (input valid, kind, char_code, col, row, output ready);
endinterface

interface tcw_out_if import tcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  cursor_pos;
  logic [DATA_W-1:0] read_data;

  modport source (output valid, cursor_pos, read_data, input ready);
  modport sink   (input valid, cursor_pos, read_data, output ready);
endinterface

@@ rtl/tcw_ram.sv @@
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/tcw_ctrl.sv @@
module tcw_ctrl import tcw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  tcw_stat_t stat,
  output tcw_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_INIT = 6'b000001,
    S_IDLE = 6'b000010,
    S_EXEC = 6'b000100,
    S_COPY = 6'b001000,
    S_FILL = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_INIT: begin
        // blank the store after reset
        cmd.wr_blank = 1'b1;
        if (stat.fill_end) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.sweep_inc = 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_DONE;
        unique case (stat.kind)
          KIND_CHAR: begin
            if (stat.is_cr) begin
              cmd.col_zero = 1'b1;
            end else if (stat.is_lf || (stat.is_print && stat.col_last)) begin
              cmd.wr_char  = stat.is_print;
              cmd.col_zero = 1'b1;
              if (stat.row_last) begin
                cmd.sweep_clr = 1'b1;
                state_nxt     = S_COPY;
              end else begin
                cmd.row_inc = 1'b1;
              end
            end else if (stat.is_print) begin
              cmd.wr_char = 1'b1;
              cmd.col_inc = 1'b1;
            end
          end
          KIND_SET: begin
            cmd.set_cursor = 1'b1;
          end
          KIND_CLEAR: begin
            cmd.sweep_clr = 1'b1;
            state_nxt     = S_FILL;
          end
          KIND_READ: begin
            cmd.rd_item = 1'b1;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_COPY: begin
        // read one line below, write the cell read in the previous cycle
        cmd.wr_copy = !stat.sweep_zero;
        if (stat.copy_end) begin
          state_nxt = S_FILL;
        end else begin
          cmd.rd_copy   = 1'b1;
          cmd.sweep_inc = 1'b1;
        end
      end
      S_FILL: begin
        cmd.wr_blank = 1'b1;
        if (stat.fill_end) begin
          state_nxt = S_DONE;
        end else begin
          cmd.sweep_inc = 1'b1;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/tcw_dp.sv @@
module tcw_dp import tcw_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  tcw_cmd_t          cmd,
  output tcw_stat_t         stat,
  input  logic [KIND_W-1:0] in_kind,
  input  logic [CHAR_W-1:0] in_char_code,
  input  logic [COL_W-1:0]  in_col,
  input  logic [ROW_W-1:0]  in_row,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [POS_W-1:0]  out_cursor_pos,
  output logic [DATA_W-1:0] out_read_data
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int COPY_N = COLUMNS * (ROWS - 1);
  localparam int CW     = $clog2(COLUMNS);
  localparam int RW     = $clog2(ROWS);
  localparam int AW     = $clog2(CELLS);

  kind_t             kind_r;
  logic [CHAR_W-1:0] ch_r;
  logic [CW-1:0]     icol_r, icol_nxt;
  logic [RW-1:0]     irow_r, irow_nxt;
  logic [CW-1:0]     cur_col_r, cur_col_nxt;
  logic [RW-1:0]     cur_row_r, cur_row_nxt;
  logic [AW-1:0]     cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]  out_pos_r;
  logic [DATA_W-1:0] out_data_r;

  logic [AW-1:0]     cur_addr, item_addr;
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;

  // position fields beyond the screen clamp to the last column or row
  assign icol_nxt = (32'(in_col) >= COLUMNS) ? CW'(COLUMNS - 1) : CW'(in_col);
  assign irow_nxt = (32'(in_row) >= ROWS)    ? RW'(ROWS - 1)    : RW'(in_row);

  assign cur_addr  = AW'(32'(cur_row_r) * COLUMNS + 32'(cur_col_r));
  assign item_addr = AW'(32'(irow_r) * COLUMNS + 32'(icol_r));

  always_comb begin
    ram_we    = cmd.wr_char | cmd.wr_blank | cmd.wr_copy;
    ram_waddr = cnt_r;
    ram_wdata = BLANK_CELL;
    if (cmd.wr_char) begin
      ram_waddr = cur_addr;
      ram_wdata = {ATTR_WHITE, ch_r};
    end else if (cmd.wr_copy) begin
      ram_waddr = cnt_r - AW'(1);
      ram_wdata = ram_rdata;
    end
    ram_re    = cmd.rd_item | cmd.rd_copy;
    ram_raddr = cmd.rd_copy ? AW'(32'(cnt_r) + COLUMNS) : item_addr;
  end

  tcw_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CELLS)
  ) u_tcw_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    cur_col_nxt = cur_col_r;
    cur_row_nxt = cur_row_r;
    if (cmd.set_cursor) begin
      cur_col_nxt = icol_r;
      cur_row_nxt = irow_r;
    end else begin
      if (cmd.col_zero) begin
        cur_col_nxt = '0;
      end else if (cmd.col_inc) begin
        cur_col_nxt = cur_col_r + CW'(1);
      end
      if (cmd.row_inc) begin
        cur_row_nxt = cur_row_r + RW'(1);
      end
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.sweep_clr) begin
      cnt_nxt = '0;
    end else if (cmd.sweep_inc) begin
      cnt_nxt = cnt_r + AW'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_col_r   <= cur_col_nxt;
      cur_row_r   <= cur_row_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= kind_t'(in_kind);
      ch_r   <= in_char_code;
      icol_r <= icol_nxt;
      irow_r <= irow_nxt;
    end
    if (cmd.load_out) begin
      out_pos_r  <= POS_W'(32'(cur_row_r) * COLUMNS + 32'(cur_col_r));
      out_data_r <= (kind_r == KIND_READ) ? ram_rdata : '0;
    end
  end

  always_comb begin
    stat.kind       = kind_r;
    stat.is_cr      = (ch_r == CHAR_CR);
    stat.is_lf      = (ch_r == CHAR_LF);
    stat.is_print   = (ch_r >= CHAR_SPACE);
    stat.col_last   = (cur_col_r == CW'(COLUMNS - 1));
    stat.row_last   = (cur_row_r == RW'(ROWS - 1));
    stat.sweep_zero = (cnt_r == '0);
    stat.copy_end   = (cnt_r == AW'(COPY_N));
    stat.fill_end   = (cnt_r == AW'(CELLS - 1));
    stat.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid      = out_valid_r;
  assign out_cursor_pos = out_pos_r;
  assign out_read_data  = out_data_r;

endmodule

@@ rtl/text_console_writer.sv @@
// Text console of COLUMNS x ROWS 16-bit cells (attribute 0x0F, character byte) with a
// cursor; every item returns the linear cursor position, and read cell items also the
// cell word. One item is in work at a time. Items that neither scroll nor clear pass
// through capture, execute and result before the next accept. Clear screen walks the
// store at one cell per cycle. A line feed or a line wrap on the last row scrolls by
// copying through the single read and single write port of the cell memory, one cell
// per cycle, then blanks the bottom line. After reset a blanking pass over all
// COLUMNS*ROWS cells (2000 at 80x25) runs before in_ch.ready rises. A finished result
// waits in the output register while the next item is taken.
module text_console_writer import tcw_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  tcw_in_if.sink     in_ch,
  tcw_out_if.source  out_ch
);

  tcw_cmd_t  cmd;
  tcw_stat_t stat;

  tcw_ctrl u_tcw_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tcw_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_tcw_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_kind        (in_ch.kind),
    .in_char_code   (in_ch.char_code),
    .in_col         (in_ch.col),
    .in_row         (in_ch.row),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_cursor_pos (out_ch.cursor_pos),
    .out_read_data  (out_ch.read_data)
  );

endmodule

@@ rtl/tcw_checker.sv @@
module tcw_checker import tcw_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [POS_W-1:0]  out_cursor_pos,
  input logic [DATA_W-1:0] out_read_data
);

  // items taken but not yet delivered
  logic [1:0] pending_r, pending_nxt;

  always_comb begin
    pending_nxt = pending_r;
    if ((in_valid && in_ready) && !(out_valid && out_ready)) begin
      pending_nxt = pending_r + 2'd1;
    end else if (!(in_valid && in_ready) && (out_valid && out_ready)) begin
      pending_nxt = pending_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_cursor_pos) && $stable(out_read_data))
    else $error("result changed while stalled");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != 2'd0)
    else $error("result without an item");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r != 2'd3)
    else $error("more than two items in flight");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_cursor_pos (out_ch.cursor_pos),
  .out_read_data  (out_ch.read_data)
);
